// ----- src/lda_pkg.sv -----
`default_nettype none
package lda_pkg;
  localparam int MaxClasses  = 8;
  localparam int MaxFeatures = 8;
  localparam int CW = $clog2(MaxClasses);
  localparam int FW = $clog2(MaxFeatures);

  localparam logic [1:0] OP_MEAN   = 2'd0;
  localparam logic [1:0] OP_ICOV   = 2'd1;
  localparam logic [1:0] OP_PRIOR  = 2'd2;
  localparam logic [1:0] OP_SAMPLE = 2'd3;

  localparam logic [1:0] REG_CLASSES  = 2'd0;
  localparam logic [1:0] REG_FEATURES = 2'd1;
  localparam logic [1:0] REG_READY    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIFF, ST_TMAC, ST_QMAC, ST_SCORE, ST_FLUSH, ST_OUT
  } lda_state_t;

  // controller -> datapath
  typedef struct packed {
    logic           diff_en;   // latch d[k]
    logic           tclr;      // clear t accumulator
    logic           tmac;      // t += S[j][k]*d[k]
    logic           qclr;      // clear q
    logic           qmac;      // q += d[j]*t
    logic           score;     // form score, compare
    logic           first;     // first class
    logic [CW-1:0]  cls;
    logic [FW-1:0]  j;
    logic [FW-1:0]  k;
  } lda_cmd_t;
endpackage
`default_nettype wire

// ----- src/lda_class_predictor_top.sv -----
`default_nettype none
// Channel   | Dir | tdata (low bit up)                                   | tuser | tlast
// s_axis    | in  | opcode, row_index, column_index, data_value (24 b)  | -     | last_feature
// m_axis    | out | predicted_class, best_score (40 b, 5 pad bits)      | -     | -
// cfg       | in  | wr_en, wr_index, wr_data (4 b)                      |       |
// Load and non-last sample words only write the tables. A last sample runs,
// per class: a difference step per feature, then nf rows of nf matrix MAC
// steps plus one outer MAC each, then a score step. A flush state then
// drains the registered table reads before the result shows.
// One shared MAC chain does all the work. The input stalls while classifying
// and while the result waits. rst is synchronous, active high.
module lda_class_predictor_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // opcode, row_index, column_index, data_value
  input  wire logic        s_axis_tlast,  // last_feature
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // predicted_class, best_score, zero pad
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [3:0]  wr_data
);
  lda_pkg::lda_state_t state;
  lda_pkg::lda_cmd_t   cmd;
  logic [3:0] class_count, feature_count;
  logic model_ready;
  logic acc, start, idle_pass;
  logic [lda_pkg::CW:0] nc;
  logic [lda_pkg::FW:0] nf;
  logic [2:0] best_class;
  logic signed [31:0] best;
  logic pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      class_count <= 4'd1; feature_count <= 4'd1; model_ready <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        lda_pkg::REG_CLASSES:  class_count <= wr_data;
        lda_pkg::REG_FEATURES: feature_count <= wr_data;
        lda_pkg::REG_READY:    model_ready <= wr_data[0];
        default: ;
      endcase
    end
  end

  // clamp counts: zero acts as one
  assign nc = (class_count == 4'd0) ? 4'd1 : (class_count > 4'd8) ? 4'd8 : class_count;
  assign nf = (feature_count == 4'd0) ? 4'd1 :
              (feature_count > 4'd8) ? 4'd8 : feature_count;

  assign s_axis_tready = (state == lda_pkg::ST_IDLE) && !pend;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign start = acc && s_axis_tdata[1:0] == lda_pkg::OP_SAMPLE && s_axis_tlast
                 && model_ready;
  assign idle_pass = acc && s_axis_tdata[1:0] == lda_pkg::OP_SAMPLE && s_axis_tlast
                     && !model_ready;

  // untrained result: hold a one-word pending flag
  always_ff @(posedge clk) begin
    if (rst) pend <= 1'b0;
    else if (idle_pass) pend <= 1'b1;
    else if (m_axis_tvalid && m_axis_tready) pend <= 1'b0;
  end

  lda_ctrl u_ctrl (
    .clk, .rst, .start, .nc, .nf,
    .out_taken(m_axis_tready), .state, .cmd
  );

  lda_datapath u_dp (
    .clk,
    .wr_en(acc), .wr_op(s_axis_tdata[1:0]), .wr_row(s_axis_tdata[4:2]),
    .wr_col(s_axis_tdata[7:5]), .wr_data(s_axis_tdata[23:8]),
    .cmd, .best_class, .best
  );

  assign m_axis_tvalid = (state == lda_pkg::ST_OUT) || pend;
  assign m_axis_tdata = pend ? 40'd0 : {5'd0, best, best_class};

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (state != lda_pkg::ST_IDLE) |-> !s_axis_tready) else $error("accepted while busy");
  a_out_only: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (pend || state == lda_pkg::ST_OUT)) else $error("stray result");
  a_no_both: assert property (@(posedge clk) disable iff (rst)
    pend |-> state == lda_pkg::ST_IDLE) else $error("pending during classify");
endmodule
`default_nettype wire

// ----- src/lda_ctrl.sv -----
`default_nettype none
module lda_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [lda_pkg::CW:0] nc,
  input  wire logic [lda_pkg::FW:0] nf,
  input  wire logic                 out_taken,
  output lda_pkg::lda_state_t       state,
  output lda_pkg::lda_cmd_t         cmd
);
  lda_pkg::lda_state_t state_next;
  logic [lda_pkg::CW:0] c;
  logic [lda_pkg::FW:0] j, k;
  logic k_end, j_end, c_end;

  assign k_end = (k + 1'b1) == nf;
  assign j_end = (j + 1'b1) == nf;
  assign c_end = (c + 1'b1) == nc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lda_pkg::ST_IDLE;
      c <= '0; j <= '0; k <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        lda_pkg::ST_IDLE: begin c <= '0; j <= '0; k <= '0; end
        lda_pkg::ST_DIFF: begin
          k <= k_end ? '0 : k + 1'b1;
        end
        lda_pkg::ST_TMAC: begin
          k <= k_end ? '0 : k + 1'b1;
        end
        lda_pkg::ST_QMAC: begin
          j <= j_end ? '0 : j + 1'b1;
        end
        lda_pkg::ST_SCORE: begin
          c <= c + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lda_pkg::ST_IDLE:  if (start) state_next = lda_pkg::ST_DIFF;
      lda_pkg::ST_DIFF:  if (k_end) state_next = lda_pkg::ST_TMAC;
      lda_pkg::ST_TMAC:  if (k_end) state_next = lda_pkg::ST_QMAC;
      lda_pkg::ST_QMAC:  state_next = j_end ? lda_pkg::ST_SCORE : lda_pkg::ST_TMAC;
      lda_pkg::ST_SCORE: state_next = c_end ? lda_pkg::ST_FLUSH : lda_pkg::ST_DIFF;
      lda_pkg::ST_FLUSH: state_next = lda_pkg::ST_OUT;
      lda_pkg::ST_OUT:   if (out_taken) state_next = lda_pkg::ST_IDLE;
      default:           state_next = lda_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.cls = c[lda_pkg::CW-1:0];
    cmd.j = j[lda_pkg::FW-1:0];
    cmd.k = k[lda_pkg::FW-1:0];
    cmd.first = (c == '0);
    unique case (state)
      lda_pkg::ST_DIFF: begin
        cmd.diff_en = 1'b1;
        cmd.tclr = 1'b1;
        cmd.qclr = 1'b1;
      end
      lda_pkg::ST_TMAC:  cmd.tmac = 1'b1;
      lda_pkg::ST_QMAC: begin
        cmd.qmac = 1'b1;
        cmd.tclr = 1'b1;
      end
      lda_pkg::ST_SCORE: cmd.score = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- src/lda_datapath.sv -----
`default_nettype none
module lda_datapath (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [1:0]           wr_op,
  input  wire logic [2:0]           wr_row,
  input  wire logic [2:0]           wr_col,
  input  wire logic signed [15:0]   wr_data,
  input  lda_pkg::lda_cmd_t         cmd,
  output logic [2:0]                best_class,
  output logic signed [31:0]        best
);
  localparam int N = lda_pkg::MaxClasses * lda_pkg::MaxFeatures;
  localparam int M = lda_pkg::MaxFeatures * lda_pkg::MaxFeatures;
  localparam logic signed [63:0] SMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

  logic signed [15:0] means [N];
  logic signed [15:0] icov  [M];
  logic signed [15:0] priors [lda_pkg::MaxClasses];
  logic signed [15:0] samples [lda_pkg::MaxFeatures];
  logic signed [16:0] d [lda_pkg::MaxFeatures];
  lda_pkg::lda_cmd_t  cmd_q;
  logic signed [15:0] mean_q, icov_q, sample_q, prior_q;
  logic signed [34:0] t;
  logic signed [63:0] q;
  logic signed [33:0] t_prod;
  logic signed [34:0] t_sum;
  logic signed [51:0] q_prod;
  logic signed [63:0] q_sum;
  logic signed [63:0] half;
  logic signed [64:0] sc_wide;
  logic signed [31:0] sc;

  // tables: written from the input word, read in clocked blocks
  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (wr_op)
        lda_pkg::OP_MEAN:   means[{wr_row, wr_col}] <= wr_data;
        lda_pkg::OP_ICOV:   icov[{wr_row, wr_col}] <= wr_data;
        lda_pkg::OP_PRIOR:  priors[wr_row] <= wr_data;
        lda_pkg::OP_SAMPLE: samples[wr_col] <= wr_data;
        default: ;
      endcase
    end
  end

  // read stage: registered table reads; register the command alongside to line up
  always_ff @(posedge clk) begin
    mean_q   <= means[{cmd.cls, cmd.k}];
    icov_q   <= icov[{cmd.j, cmd.k}];
    sample_q <= samples[cmd.k];
    prior_q  <= priors[cmd.cls];
    cmd_q    <= cmd;
  end

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return SMAX;
    if (s < -65'sh0_8000_0000_0000_0000) return SMIN;
    return s[63:0];
  endfunction

  // |d| < 2^16, |S*d| < 2^31, |t| < 2^34, |d*t| < 2^50: none of these can saturate
  assign t_prod = icov_q * d[cmd_q.k];
  assign t_sum = t + 35'(t_prod);
  assign q_prod = d[cmd_q.j] * t;
  assign q_sum = sadd(q, 64'(q_prod));
  assign half = q >>> 13;
  assign sc_wide = {{41{prior_q[15]}}, prior_q, 8'd0} - {half[63], half};
  assign sc = (sc_wide > 65'sd2147483647) ? 32'sh7FFF_FFFF :
              (sc_wide < -65'sd2147483648) ? 32'sh8000_0000 : sc_wide[31:0];

  always_ff @(posedge clk) begin
    if (cmd_q.diff_en) d[cmd_q.k] <= sample_q - mean_q;
    if (cmd_q.tclr) t <= '0;
    else if (cmd_q.tmac) t <= t_sum;
    if (cmd_q.qclr) q <= '0;
    else if (cmd_q.qmac) q <= q_sum;
    if (cmd_q.score && (cmd_q.first || sc > best)) begin
      best <= sc;
      best_class <= 3'(cmd_q.cls);
    end
  end
endmodule
`default_nettype wire

// ----- tb/sv/tb_lda_class_predictor_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_lda_class_predictor_top;

  // idling modes, chosen per word
  localparam int ModeNone    = 0;
  localparam int ModeSrcIdle = 1;
  localparam int ModeSnkIdle = 2;
  localparam int ModeBoth    = 3;

  localparam int SettleCycles = 300;   // quiet gap before a register write and at the end
  localparam int CycleLimit   = 3000000;

  typedef struct {
    logic        is_cfg;
    logic [1:0]  reg_idx;
    logic [3:0]  reg_val;
    logic [1:0]  op;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [15:0] value;
    logic        last;
    int          mode;
  } lda_word_t;

  typedef struct {
    logic [2:0]  cls;
    logic [31:0] score;
  } lda_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = '0;
  logic [3:0]  wr_data = '0;

  lda_word_t   word_q[$];
  lda_result_t predicted_results[$];
  lda_word_t   in_flight;
  int          cur_mode = ModeNone;
  int          quiet_cycles = 0;
  int          cycle_count = 0;
  int          error_count = 0;

  // shadow copy of the model tables and registers
  logic signed [15:0] mean_tab [lda_pkg::MaxClasses][lda_pkg::MaxFeatures];
  logic signed [15:0] icov_tab [lda_pkg::MaxFeatures][lda_pkg::MaxFeatures];
  logic signed [15:0] prior_tab[lda_pkg::MaxClasses];
  logic signed [15:0] sample_tab[lda_pkg::MaxFeatures];
  logic [3:0]         classes_reg = 4'd1;
  logic [3:0]         features_reg = 4'd1;
  logic               ready_reg = 1'b0;

  lda_class_predictor_top u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // opcode, row_index, column_index, data_value
    .s_axis_tlast (s_axis_tlast),   // last_feature
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // predicted_class, best_score, zero pad
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Fixed-point helpers: 64-bit saturating add and multiply
  // ---------------------------------------------------------------------
  function automatic longint sat_add(longint a, longint b);
    logic signed [65:0] s;
    s = 66'(signed'(a)) + 66'(signed'(b));
    if (s > 66'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -66'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(s);
  endfunction

  function automatic longint sat_mul(longint a, longint b);
    logic signed [127:0] p;
    logic signed [127:0] wa;
    logic signed [127:0] wb;
    wa = a;
    wb = b;
    p = wa * wb;
    if (p > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (p < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(p);
  endfunction

  function automatic int clamp_count(logic [3:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  // Discriminant score of one class, Q16.16 saturated to 32 bits
  function automatic longint discriminant(int c, int nf);
    longint d[lda_pkg::MaxFeatures];
    longint q;
    longint t;
    longint half;
    longint s;
    q = 0;
    for (int k = 0; k < nf; k++)
      d[k] = sat_add(longint'(sample_tab[k]), -longint'(mean_tab[c][k]));
    for (int j = 0; j < nf; j++) begin
      t = 0;
      for (int k = 0; k < nf; k++)
        t = sat_add(t, sat_mul(longint'(icov_tab[j][k]), d[k]));
      q = sat_add(q, sat_mul(d[j], t));
    end
    half = q >>> 13;   // floor of q / 2^13
    s = sat_add(sat_mul(longint'(prior_tab[c]), 256), -half);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  // Apply one accepted word to the shadow tables; queue a result on a last sample
  task automatic apply_word(lda_word_t w);
    lda_result_t r;
    longint best;
    longint s;
    int nc;
    int nf;
    case (w.op)
      lda_pkg::OP_MEAN:   mean_tab[w.row][w.col] = w.value;
      lda_pkg::OP_ICOV:   icov_tab[w.row][w.col] = w.value;
      lda_pkg::OP_PRIOR:  prior_tab[w.row] = w.value;
      lda_pkg::OP_SAMPLE: begin
        sample_tab[w.col] = w.value;
        if (w.last) begin
          r.cls = '0;
          best = 0;
          if (ready_reg) begin
            nc = clamp_count(classes_reg, lda_pkg::MaxClasses);
            nf = clamp_count(features_reg, lda_pkg::MaxFeatures);
            for (int c = 0; c < nc; c++) begin
              s = discriminant(c, nf);
              // ties keep the lower class
              if (c == 0 || s > best) begin
                best = s;
                r.cls = 3'(c);
              end
            end
          end
          r.score = best[31:0];
          predicted_results.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // ---------------------------------------------------------------------
  // Driver: feed words from word_q; register writes only once fully idle
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    logic      nvalid;
    logic      nwr;
    lda_word_t h;
    int        idle_pct;
    nvalid = s_axis_tvalid;
    nwr = 1'b0;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_word(in_flight);
        nvalid = 1'b0;
      end
      if (!nvalid && word_q.size() > 0) begin
        h = word_q[0];
        if (h.is_cfg) begin
          // hold until every result is out and the pipe has settled
          if (predicted_results.size() == 0 && quiet_cycles >= SettleCycles && !wr_en) begin
            nwr = 1'b1;
            wr_index <= h.reg_idx;
            wr_data <= h.reg_val;
            case (h.reg_idx)
              lda_pkg::REG_CLASSES:  classes_reg = h.reg_val;
              lda_pkg::REG_FEATURES: features_reg = h.reg_val;
              lda_pkg::REG_READY:    ready_reg = h.reg_val[0];
              default: ;
            endcase
            void'(word_q.pop_front());
          end
        end else begin
          cur_mode = h.mode;
          idle_pct = (h.mode == ModeSrcIdle) ? 81 : (h.mode == ModeBoth) ? 6 : 0;
          if ($urandom_range(99) >= idle_pct) begin
            s_axis_tdata <= {h.value, h.col, h.row, h.op};
            s_axis_tlast <= h.last;
            in_flight = h;
            nvalid = 1'b1;
            void'(word_q.pop_front());
          end
        end
      end
    end
    s_axis_tvalid <= nvalid;
    wr_en <= nwr;
  end

  // ---------------------------------------------------------------------
  // Monitor: randomize tready, check each result against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    int          stall_pct;
    lda_result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(m_axis_tdata[34:0]), '0);
        end else begin
          want = predicted_results.pop_front();
          if (m_axis_tdata[2:0] !== want.cls)
            report_mismatch("predicted_class", 32'(m_axis_tdata[2:0]), 32'(want.cls));
          if (m_axis_tdata[34:3] !== want.score)
            report_mismatch("best_score", m_axis_tdata[34:3], want.score);
        end
      end
    end
    stall_pct = (cur_mode == ModeSnkIdle) ? 81 : (cur_mode == ModeBoth) ? 6 : 0;
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // quiet counter and the overall timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (s_axis_tvalid || m_axis_tvalid || wr_en)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic push_word(logic [1:0] op, int row, int col, logic [15:0] v, logic last,
                           int mode);
    lda_word_t w;
    w.is_cfg = 1'b0;
    w.reg_idx = '0;
    w.reg_val = '0;
    w.op = op;
    w.row = 3'(row);
    w.col = 3'(col);
    w.value = v;
    w.last = last;
    w.mode = mode;
    word_q.push_back(w);
  endtask

  task automatic push_cfg(logic [1:0] idx, int v);
    lda_word_t w;
    w = '{default: '0};
    w.is_cfg = 1'b1;
    w.reg_idx = idx;
    w.reg_val = 4'(v);
    word_q.push_back(w);
  endtask

  // moderate random value so scores mostly stay unsaturated
  function automatic logic [15:0] rand_value();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      default: return 16'($signed($urandom_range(1024)) - 512);
    endcase
  endfunction

  // one sample: a run of features ending with the last flag, with some stray loads
  task automatic push_sample(int mode);
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        push_word(2'($urandom_range(lda_pkg::OP_PRIOR)), $urandom_range(7),
                  $urandom_range(7), rand_value(), 1'($urandom), mode);
      push_word(lda_pkg::OP_SAMPLE, $urandom_range(7), $urandom_range(7), rand_value(),
                i == n - 1, mode);
    end
  endtask

  initial begin
    int mode;
    // load every table entry first, so no entry is ever read unwritten
    for (int r = 0; r < lda_pkg::MaxClasses; r++) begin
      for (int c = 0; c < lda_pkg::MaxFeatures; c++) begin
        push_word(lda_pkg::OP_MEAN, r, c, rand_value(), 1'b0, ModeNone);
        push_word(lda_pkg::OP_ICOV, r, c, rand_value(), 1'b0, ModeNone);
      end
      push_word(lda_pkg::OP_PRIOR, r, 0, rand_value(), 1'b0, ModeNone);
      push_word(lda_pkg::OP_SAMPLE, 0, r, rand_value(), 1'b0, ModeNone);
    end

    // directed: untrained model gives class 0, score 0
    push_word(lda_pkg::OP_SAMPLE, 0, 0, 16'h7FFF, 1'b1, ModeNone);
    push_cfg(lda_pkg::REG_READY, 1);
    push_cfg(lda_pkg::REG_CLASSES, 8);
    push_cfg(lda_pkg::REG_FEATURES, 8);
    // extreme features against extreme means and covariance: drives saturation
    push_word(lda_pkg::OP_MEAN, 0, 0, 16'h8000, 1'b1, ModeNone);  // last flag on a load is ignored
    push_word(lda_pkg::OP_ICOV, 0, 0, 16'h7FFF, 1'b1, ModeNone);
    push_word(lda_pkg::OP_PRIOR, 7, 0, 16'h7FFF, 1'b1, ModeNone);
    push_word(lda_pkg::OP_SAMPLE, 0, 0, 16'h7FFF, 1'b0, ModeNone);
    push_word(lda_pkg::OP_SAMPLE, 0, 7, 16'h8000, 1'b1, ModeNone);
    // equal priors, equal means in column 0: any tie goes to the lowest class
    for (int r = 0; r < lda_pkg::MaxClasses; r++) begin
      push_word(lda_pkg::OP_PRIOR, r, 0, 16'h0100, 1'b0, ModeNone);
      push_word(lda_pkg::OP_MEAN, r, 0, 16'h0000, 1'b0, ModeNone);
    end
    push_word(lda_pkg::OP_SAMPLE, 0, 0, 16'h0000, 1'b1, ModeNone);
    // zero counts act as one, counts above the table size act as the maximum
    push_cfg(lda_pkg::REG_CLASSES, 0);
    push_cfg(lda_pkg::REG_FEATURES, 0);
    push_word(lda_pkg::OP_SAMPLE, 0, 0, 16'h8000, 1'b1, ModeNone);
    push_cfg(lda_pkg::REG_CLASSES, 15);
    push_cfg(lda_pkg::REG_FEATURES, 15);
    push_word(lda_pkg::OP_SAMPLE, 0, 3, 16'hFFFF, 1'b1, ModeNone);

    // random phases; the phases cycle through the idling modes
    for (int p = 0; p < 8; p++) begin
      mode = p % 4;
      push_cfg(lda_pkg::REG_CLASSES, (p == 1) ? 1 : (p == 2) ? 8 : $urandom_range(15));
      push_cfg(lda_pkg::REG_FEATURES, (p == 1) ? 8 : (p == 2) ? 1 : $urandom_range(15));
      push_cfg(lda_pkg::REG_READY, (p == 5) ? 0 : 1);
      for (int i = 0; i < 30; i++) begin
        if ($urandom_range(2) == 0)
          push_word(2'($urandom_range(lda_pkg::OP_PRIOR)), $urandom_range(7),
                    $urandom_range(7), rand_value(), 1'($urandom), mode);
        else
          push_sample(mode);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // drain: all words sent, all results seen, then let the pipe settle
    wait (word_q.size() == 0 && !s_axis_tvalid && predicted_results.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0 && predicted_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
